/* rtl/core/chs_pkg.sv */
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types and constants for the chained hash set.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int unsigned NUM_BUCKETS_DEF = 10;
  localparam int unsigned CHAIN_DEPTH_DEF = 8;
  localparam int unsigned KEY_CHARS       = 12;

  localparam int unsigned HALF_W      = 48;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned HALF_CHARS  = 6;
  // sum of one half fits 10 bits, of the whole key 11 bits
  localparam int unsigned HSUM_W      = 10;
  localparam int unsigned SUM_W       = 11;
  localparam int unsigned BKT_MAX_W   = 6;
  localparam int unsigned OUT_BKT_W   = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [HALF_W-1:0] SEVEN_BIT_MASK = 48'h7F7F_7F7F_7F7F;
  localparam logic [LEN_W-1:0]  KEY_LEN        = LEN_W'(KEY_CHARS);

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_FULL      = 3'd3,
    ST_SEARCHED  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    JOB_INSERT,
    JOB_SEARCH,
    JOB_SHORT,
    JOB_LONG,
    JOB_MISS
  } job_kind_t;

  typedef struct packed {
    op_t               opcode;
    logic [HALF_W-1:0] key_high;
    logic [HALF_W-1:0] key_low;
    logic [LEN_W-1:0]  key_length;
  } in_item_t;

  typedef struct packed {
    status_t              status;
    logic                 found;
    logic [OUT_BKT_W-1:0] bucket;
  } out_item_t;

  typedef struct packed {
    job_kind_t            kind;
    logic [HALF_W-1:0]    key_high;
    logic [HALF_W-1:0]    key_low;
    logic [BKT_MAX_W-1:0] bucket;
  } job_t;

endpackage

/* rtl/core/chained_hash_set_insert_search.sv */
// ----------------------------------------------------------------------------
// chained_hash_set_insert_search
// Hash set of 12-character keys with bounded per-bucket chains.
// ----------------------------------------------------------------------------
// Each input beat is an insert or a search; each gives exactly one result
// beat, in order. The front stage takes one item at a time and stays busy
// until its job is in the queue, which can wait on a full queue: capture,
// two half sums, full sum, reciprocal multiply, remainder and queue write.
// The back end finishes an insert or a rejected item without a walk, and a
// search by comparing k stored keys, k being at most the chain length,
// one key per cycle through the key store's single read port.
// Sustained rate is set by the slower of the two. Chain counts clear at
// reset; the key store needs no clearing.
module chained_hash_set_insert_search #(
  parameter int unsigned NUM_BUCKETS = chs_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned CHAIN_DEPTH = chs_pkg::CHAIN_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  chs_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output chs_pkg::out_item_t out_data
);

  chs_pkg::job_t front_job, back_job;
  logic          job_wr, job_rd, job_full, job_empty;

  chs_front #(
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .job_wr   (job_wr),
    .job      (front_job),
    .job_full (job_full)
  );

  chs_fifo #(
    .WIDTH ($bits(chs_pkg::job_t)),
    .DEPTH (chs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (job_wr),
    .wr_data (front_job),
    .q_full  (job_full),
    .rd_en   (job_rd),
    .rd_data (back_job),
    .q_empty (job_empty)
  );

  chs_back #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .CHAIN_DEPTH (CHAIN_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (back_job),
    .job_empty (job_empty),
    .job_rd    (job_rd),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full) |=> full)
    else $error("front took a beat without going busy");

  a_found_only_search: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.found) |-> (out_data.status == chs_pkg::ST_SEARCHED))
    else $error("found flag on a non-search result");

  a_reject_no_bucket: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_data.status == chs_pkg::ST_TOO_SHORT ||
                out_data.status == chs_pkg::ST_TOO_LONG))
      |-> (out_data.bucket == '0 && !out_data.found))
    else $error("rejected insert carries a bucket");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    job_wr |-> !job_full)
    else $error("job written into a full queue");

endmodule

/* rtl/core/chs_ram.sv */
// ----------------------------------------------------------------------------
// chs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/chs_fifo.sv */
// ----------------------------------------------------------------------------
// chs_fifo
// Short job queue between the classifying front and the table back end.
// ----------------------------------------------------------------------------
module chs_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             q_full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             q_empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign q_full  = (count_r == CNT_W'(DEPTH));
  assign q_empty = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (do_rd && !do_wr) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* rtl/core/chs_front.sv */
// ----------------------------------------------------------------------------
// chs_front
// Accepts items, masks keys to 7-bit characters, hashes and classifies them.
// ----------------------------------------------------------------------------
module chs_front #(
  parameter int unsigned NUM_BUCKETS = chs_pkg::NUM_BUCKETS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  chs_pkg::in_item_t in_data,
  output logic             full,
  output logic             job_wr,
  output chs_pkg::job_t    job,
  input  logic             job_full
);

  localparam int unsigned SUM_W      = chs_pkg::SUM_W;
  localparam int unsigned HSUM_W     = chs_pkg::HSUM_W;
  localparam int unsigned HASH_SHIFT = 22;
  localparam int unsigned PROD_W     = SUM_W + HASH_SHIFT;
  localparam logic [HASH_SHIFT-1:0] RECIP = HASH_SHIFT'((1 << HASH_SHIFT) / NUM_BUCKETS);
  localparam logic [SUM_W:0]        NB_W  = (SUM_W + 1)'(NUM_BUCKETS);

  typedef enum logic [2:0] {
    F_IDLE,
    F_HALF,
    F_SUM,
    F_MUL,
    F_PUSH
  } f_state_t;

  f_state_t                        state_r, state_nxt;
  logic [chs_pkg::HALF_W-1:0]      kh_r, kl_r;
  chs_pkg::op_t                    op_r;
  logic [chs_pkg::LEN_W-1:0]       len_r;
  logic [HSUM_W-1:0]               hsum_hi_r, hsum_lo_r;
  logic [HSUM_W-1:0]               hsum_hi, hsum_lo;
  logic [SUM_W-1:0]                sum_r;
  logic [SUM_W-1:0]                quot_r;
  logic [PROD_W-1:0]               prod;
  logic [SUM_W:0]                  qn, rem_raw, rem;
  logic                            len_ok;

  assign full = (state_r != F_IDLE);

  always_comb begin
    hsum_hi = '0;
    hsum_lo = '0;
    for (int i = 0; i < chs_pkg::HALF_CHARS; i++) begin
      hsum_hi = HSUM_W'(hsum_hi + HSUM_W'(kh_r[8*i +: chs_pkg::CHAR_W]));
      hsum_lo = HSUM_W'(hsum_lo + HSUM_W'(kl_r[8*i +: chs_pkg::CHAR_W]));
    end
  end

  assign prod = {{HASH_SHIFT{1'b0}}, sum_r} * {{SUM_W{1'b0}}, RECIP};

  // quotient estimate is at most one low, so one correction step suffices
  always_comb begin
    qn      = {1'b0, quot_r} * NB_W;
    rem_raw = {1'b0, sum_r} - qn;
    rem     = (rem_raw >= NB_W) ? (rem_raw - NB_W) : rem_raw;
  end

  assign len_ok = (len_r == chs_pkg::KEY_LEN);

  always_comb begin
    job.key_high = kh_r;
    job.key_low  = kl_r;
    job.bucket   = len_ok ? chs_pkg::BKT_MAX_W'(rem) : '0;
    if (op_r == chs_pkg::OP_SEARCH) begin
      job.kind = len_ok ? chs_pkg::JOB_SEARCH : chs_pkg::JOB_MISS;
    end else if (len_r < chs_pkg::KEY_LEN) begin
      job.kind = chs_pkg::JOB_SHORT;
    end else if (len_r > chs_pkg::KEY_LEN) begin
      job.kind = chs_pkg::JOB_LONG;
    end else begin
      job.kind = chs_pkg::JOB_INSERT;
    end
  end

  assign job_wr = (state_r == F_PUSH) && !job_full;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (push) state_nxt = F_HALF;
      end
      F_HALF:  state_nxt = F_SUM;
      F_SUM:   state_nxt = F_MUL;
      F_MUL:   state_nxt = F_PUSH;
      F_PUSH: begin
        if (!job_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && push) begin
      op_r  <= in_data.opcode;
      kh_r  <= in_data.key_high & chs_pkg::SEVEN_BIT_MASK;
      kl_r  <= in_data.key_low & chs_pkg::SEVEN_BIT_MASK;
      len_r <= in_data.key_length;
    end
    if (state_r == F_HALF) begin
      hsum_hi_r <= hsum_hi;
      hsum_lo_r <= hsum_lo;
    end
    if (state_r == F_SUM) begin
      sum_r <= SUM_W'({1'b0, hsum_hi_r} + {1'b0, hsum_lo_r});
    end
    if (state_r == F_MUL) begin
      quot_r <= prod[PROD_W-1:HASH_SHIFT];
    end
  end

endmodule

/* rtl/core/chs_back.sv */
// ----------------------------------------------------------------------------
// chs_back
// Carries out jobs: chain counts, key store, chain walk and result register.
// ----------------------------------------------------------------------------
module chs_back #(
  parameter int unsigned NUM_BUCKETS = chs_pkg::NUM_BUCKETS_DEF,
  parameter int unsigned CHAIN_DEPTH = chs_pkg::CHAIN_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  chs_pkg::job_t      job,
  input  logic               job_empty,
  output logic               job_rd,
  output logic               empty,
  input  logic               pop,
  output chs_pkg::out_item_t out_data
);

  localparam int unsigned BKT_W  = $clog2(NUM_BUCKETS);
  localparam int unsigned CNT_W  = $clog2(CHAIN_DEPTH + 1);
  localparam int unsigned SLOTS  = NUM_BUCKETS * CHAIN_DEPTH;
  localparam int unsigned ADDR_W = $clog2(SLOTS);
  localparam int unsigned KEY_W  = 2 * chs_pkg::HALF_W;

  typedef enum logic [0:0] {
    B_IDLE,
    B_WALK
  } b_state_t;

  b_state_t            state_r, state_nxt;
  chs_pkg::job_t       job_r, job_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [CNT_W-1:0]    chain_r [NUM_BUCKETS];
  logic [CNT_W-1:0]    chain_nxt [NUM_BUCKETS];
  logic                out_valid_r, out_valid_nxt;
  chs_pkg::out_item_t  out_r, out_nxt;

  logic [BKT_W-1:0]    bkt;
  logic [BKT_W+3:0]    bkt_ext;
  logic [CNT_W-1:0]    cnt;
  logic [ADDR_W-1:0]   base;
  logic                out_free;
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [KEY_W-1:0]    ram_rdata;
  logic                hit;
  logic [CNT_W-1:0]    idx_inc;

  assign bkt      = (state_r == B_IDLE) ? job.bucket[BKT_W-1:0] : job_r.bucket[BKT_W-1:0];
  assign bkt_ext  = {4'b0, bkt};
  assign cnt      = chain_r[bkt];
  assign base     = ADDR_W'(bkt * CHAIN_DEPTH);
  assign out_free = !out_valid_r || pop;
  assign hit      = (ram_rdata == {job_r.key_high, job_r.key_low});
  assign idx_inc  = CNT_W'(idx_r + 1'b1);
  assign empty    = !out_valid_r;
  assign out_data = out_r;

  chs_ram #(
    .WIDTH (KEY_W),
    .DEPTH (SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({job.key_high, job.key_low}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    chain_nxt     = chain_r;
    out_valid_nxt = out_valid_r && !pop;
    out_nxt       = out_r;
    job_rd        = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = ADDR_W'(base + ADDR_W'(cnt));
    ram_raddr     = base;
    case (state_r)
      B_IDLE: begin
        if (!job_empty && out_free) begin
          job_rd        = 1'b1;
          out_valid_nxt = 1'b1;
          out_nxt.found = 1'b0;
          out_nxt.bucket = '0;
          case (job.kind)
            chs_pkg::JOB_INSERT: begin
              out_nxt.bucket = bkt_ext[3:0];
              if (cnt >= CNT_W'(CHAIN_DEPTH)) begin
                out_nxt.status = chs_pkg::ST_FULL;
              end else begin
                out_nxt.status = chs_pkg::ST_INSERTED;
                ram_we         = 1'b1;
                chain_nxt[bkt] = CNT_W'(cnt + 1'b1);
              end
            end
            chs_pkg::JOB_SEARCH: begin
              out_nxt.status = chs_pkg::ST_SEARCHED;
              out_nxt.bucket = bkt_ext[3:0];
              if (cnt != '0) begin
                out_valid_nxt = 1'b0;
                ram_re        = 1'b1;
                job_nxt       = job;
                idx_nxt       = '0;
                n_nxt         = cnt;
                state_nxt     = B_WALK;
              end
            end
            chs_pkg::JOB_SHORT: out_nxt.status = chs_pkg::ST_TOO_SHORT;
            chs_pkg::JOB_LONG:  out_nxt.status = chs_pkg::ST_TOO_LONG;
            default:            out_nxt.status = chs_pkg::ST_SEARCHED;
          endcase
        end
      end
      B_WALK: begin
        // read data holds the stored key at idx_r
        if (hit || idx_inc == n_r) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = chs_pkg::ST_SEARCHED;
          out_nxt.found  = hit;
          out_nxt.bucket = bkt_ext[3:0];
          state_nxt      = B_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ADDR_W'(base + ADDR_W'(idx_inc));
          idx_nxt   = idx_inc;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        chain_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      chain_r     <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    idx_r <= idx_nxt;
    n_r   <= n_nxt;
    out_r <= out_nxt;
  end

endmodule

/* test/chained_hash_set_insert_search_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_set_insert_search_test
// Self-checking bench for the chained hash set.
// ----------------------------------------------------------------------------
// A short directed run covers the key extremes, bad lengths, masking of bit 7
// and filling one chain to overflow. A long random run follows, biased
// towards inserts and searches of keys already seen. A shadow copy of the
// chains predicts every result beat, which is checked field by field, in
// order. Both sides idle in random bursts, and the result side holds off once
// for long enough to back the block up.
// ----------------------------------------------------------------------------
module chained_hash_set_insert_search_test;

  localparam int NB           = chs_pkg::NUM_BUCKETS_DEF;
  localparam int CD           = chs_pkg::CHAIN_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1400;
  localparam int CALM_FROM    = 1200;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 20000;

  class hash_set_tracker;
    int unsigned                chain_count [NB];
    logic [chs_pkg::HALF_W-1:0] chain_high [NB][CD];
    logic [chs_pkg::HALF_W-1:0] chain_low [NB][CD];
    chs_pkg::out_item_t         expected_q [$];
    int errors, items, stored, rejected_full, bad_length, searches, hits;

    function new();
      foreach (chain_count[b]) chain_count[b] = 0;
      errors = 0;
      items = 0;
      stored = 0;
      rejected_full = 0;
      bad_length = 0;
      searches = 0;
      hits = 0;
    endfunction

    function void note_item(chs_pkg::in_item_t it);
      logic [chs_pkg::HALF_W-1:0] kh;
      logic [chs_pkg::HALF_W-1:0] kl;
      int                         sum;
      int                         b;
      chs_pkg::out_item_t         res;
      kh = it.key_high & chs_pkg::SEVEN_BIT_MASK;
      kl = it.key_low & chs_pkg::SEVEN_BIT_MASK;
      sum = 0;
      b = 0;
      res.found = 1'b0;
      items++;
      if (it.key_length == chs_pkg::KEY_LEN) begin
        for (int i = 0; i < chs_pkg::HALF_CHARS; i++) begin
          sum += int'(kh[8*i +: chs_pkg::CHAR_W]) + int'(kl[8*i +: chs_pkg::CHAR_W]);
        end
        b = sum % NB;
      end
      if (it.opcode == chs_pkg::OP_INSERT) begin
        if (it.key_length < chs_pkg::KEY_LEN) begin
          res.status = chs_pkg::ST_TOO_SHORT;
          bad_length++;
        end else if (it.key_length > chs_pkg::KEY_LEN) begin
          res.status = chs_pkg::ST_TOO_LONG;
          bad_length++;
        end else if (chain_count[b] >= CD) begin
          res.status = chs_pkg::ST_FULL;
          rejected_full++;
        end else begin
          chain_high[b][chain_count[b]] = kh;
          chain_low[b][chain_count[b]] = kl;
          chain_count[b]++;
          res.status = chs_pkg::ST_INSERTED;
          stored++;
        end
      end else begin
        res.status = chs_pkg::ST_SEARCHED;
        searches++;
        if (it.key_length == chs_pkg::KEY_LEN) begin
          for (int i = 0; i < chain_count[b]; i++) begin
            if (chain_high[b][i] == kh && chain_low[b][i] == kl) res.found = 1'b1;
          end
        end
        if (res.found) hits++;
      end
      res.bucket = chs_pkg::OUT_BKT_W'(b);
      expected_q.push_back(res);
    endfunction

    function void check_result(chs_pkg::out_item_t got);
      chs_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: %p", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.found !== want.found) begin
        $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
        errors++;
      end
      if (got.bucket !== want.bucket) begin
        $display("%0t: bucket expected %0d actual %0d", $time, want.bucket, got.bucket);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n   = 1'b0;
  logic               push    = 1'b0;
  logic               pop     = 1'b0;
  chs_pkg::in_item_t  in_data = '0;
  logic               full;
  logic               empty;
  chs_pkg::out_item_t out_data;

  bit hold_rx = 1'b0;
  bit calm    = 1'b0;

  hash_set_tracker            tracker = new();
  logic [chs_pkg::HALF_W-1:0] seen_high [$];
  logic [chs_pkg::HALF_W-1:0] seen_low [$];

  chained_hash_set_insert_search #(
    .NUM_BUCKETS(NB),
    .CHAIN_DEPTH(CD)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .empty   (empty),
    .pop     (pop),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) tracker.note_item(in_data);
      if (pop && !empty) tracker.check_result(out_data);
    end
  end

  function automatic chs_pkg::in_item_t make_item(chs_pkg::op_t op,
                                                  logic [chs_pkg::HALF_W-1:0] kh,
                                                  logic [chs_pkg::HALF_W-1:0] kl,
                                                  logic [chs_pkg::LEN_W-1:0] len);
    chs_pkg::in_item_t it;
    it.opcode = op;
    it.key_high = kh;
    it.key_low = kl;
    it.key_length = len;
    return it;
  endfunction

  function automatic logic [chs_pkg::HALF_W-1:0] rand_half();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [chs_pkg::LEN_W-1:0] rand_bad_len();
    logic [chs_pkg::LEN_W-1:0] len;
    len = chs_pkg::LEN_W'($urandom_range(15, 0));
    if (len == chs_pkg::KEY_LEN) len = chs_pkg::LEN_W'($urandom_range(11, 0));
    return len;
  endfunction

  function automatic chs_pkg::in_item_t random_item();
    int                         pick;
    int                         idx;
    logic [chs_pkg::HALF_W-1:0] kh;
    logic [chs_pkg::HALF_W-1:0] kl;
    logic [chs_pkg::HALF_W-1:0] bit7_h;
    logic [chs_pkg::HALF_W-1:0] bit7_l;
    pick = $urandom_range(99, 0);
    kh = rand_half();
    kl = rand_half();
    bit7_h = rand_half() & ~chs_pkg::SEVEN_BIT_MASK;
    bit7_l = rand_half() & ~chs_pkg::SEVEN_BIT_MASK;
    if (seen_high.size() == 0) pick = 0;
    idx = $urandom_range(seen_high.size() == 0 ? 0 : seen_high.size() - 1, 0);
    if (pick < 18) begin
      seen_high.push_back(kh);
      seen_low.push_back(kl);
      return make_item(chs_pkg::OP_INSERT, kh, kl, chs_pkg::KEY_LEN);
    end else if (pick < 24) begin
      return make_item(chs_pkg::OP_INSERT, seen_high[idx], seen_low[idx], chs_pkg::KEY_LEN);
    end else if (pick < 60) begin
      return make_item(chs_pkg::OP_SEARCH, seen_high[idx] ^ bit7_h, seen_low[idx] ^ bit7_l,
                       chs_pkg::KEY_LEN);
    end else if (pick < 75) begin
      return make_item(chs_pkg::OP_SEARCH, kh, kl, chs_pkg::KEY_LEN);
    end else if (pick < 85) begin
      return make_item(chs_pkg::OP_SEARCH, seen_high[idx], seen_low[idx], rand_bad_len());
    end else if (pick < 95) begin
      return make_item(chs_pkg::OP_INSERT, kh, kl, chs_pkg::LEN_W'($urandom_range(15, 0)));
    end
    return make_item(chs_pkg::OP_SEARCH, kh, kl, chs_pkg::LEN_W'($urandom_range(15, 0)));
  endfunction

  task automatic send_item(chs_pkg::in_item_t it);
    push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic maybe_idle_tx();
    if (!calm && $urandom_range(3, 0) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  initial begin
    bit held;
    held = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_rx && !held) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else if (!calm && $urandom_range(3, 0) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(6, 1)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    #3_200_000;
    $display("%0t: run limit reached", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int waited;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // key extremes, masking of bit 7, bad lengths
    send_item(make_item(chs_pkg::OP_INSERT, '0, '0, chs_pkg::KEY_LEN));
    send_item(make_item(chs_pkg::OP_INSERT, chs_pkg::SEVEN_BIT_MASK, chs_pkg::SEVEN_BIT_MASK,
                        chs_pkg::KEY_LEN));
    maybe_idle_tx();
    send_item(make_item(chs_pkg::OP_SEARCH, '1, '1, chs_pkg::KEY_LEN));
    send_item(make_item(chs_pkg::OP_INSERT, '1, '1, chs_pkg::KEY_LEN));
    send_item(make_item(chs_pkg::OP_INSERT, '1, '1, 4'd0));
    send_item(make_item(chs_pkg::OP_INSERT, chs_pkg::SEVEN_BIT_MASK, '0, 4'd11));
    send_item(make_item(chs_pkg::OP_INSERT, '0, chs_pkg::SEVEN_BIT_MASK, 4'd13));
    send_item(make_item(chs_pkg::OP_INSERT, '1, '0, 4'd15));
    send_item(make_item(chs_pkg::OP_SEARCH, '0, '0, 4'd0));
    send_item(make_item(chs_pkg::OP_SEARCH, chs_pkg::SEVEN_BIT_MASK, chs_pkg::SEVEN_BIT_MASK,
                        4'd15));
    send_item(make_item(chs_pkg::OP_SEARCH, '0, 48'd1, chs_pkg::KEY_LEN));
    // fill bucket zero to its limit, then overflow it
    for (int i = 1; i < CD; i++) begin
      send_item(make_item(chs_pkg::OP_INSERT, '0, chs_pkg::HALF_W'(10 * i), chs_pkg::KEY_LEN));
      maybe_idle_tx();
    end
    send_item(make_item(chs_pkg::OP_INSERT, '0, chs_pkg::HALF_W'(10 * CD), chs_pkg::KEY_LEN));
    send_item(make_item(chs_pkg::OP_INSERT, ~chs_pkg::SEVEN_BIT_MASK, ~chs_pkg::SEVEN_BIT_MASK,
                        chs_pkg::KEY_LEN));
    send_item(make_item(chs_pkg::OP_SEARCH, '0, chs_pkg::HALF_W'(10 * (CD - 1)),
                        chs_pkg::KEY_LEN));
    send_item(make_item(chs_pkg::OP_SEARCH, '0, chs_pkg::HALF_W'(10 * CD), chs_pkg::KEY_LEN));
    send_item(make_item(chs_pkg::OP_SEARCH, ~chs_pkg::SEVEN_BIT_MASK, '0, chs_pkg::KEY_LEN));

    hold_rx = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == CALM_FROM) calm = 1'b1;
      send_item(random_item());
      maybe_idle_tx();
    end
    push <= 1'b0;

    waited = 0;
    while (tracker.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (tracker.pending() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, tracker.pending());
      $display("SCOREBOARD MISMATCH");
    end else begin
      repeat (40) @(posedge clk);
      $display("Ran %0d items: %0d stored, %0d rejected on a full chain, %0d bad length,",
               tracker.items, tracker.stored, tracker.rejected_full, tracker.bad_length);
      $display("%0d searches with %0d hits, one long result hold-off.",
               tracker.searches, tracker.hits);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
        $display("SCOREBOARD CLEAN");
      end else begin
        $display("SCOREBOARD MISMATCH");
      end
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/chs_pkg.sv
rtl/core/chs_ram.sv
rtl/core/chs_fifo.sv
rtl/core/chs_front.sv
rtl/core/chs_back.sv
rtl/core/chained_hash_set_insert_search.sv
test/chained_hash_set_insert_search_test.sv
